// File: src/kcc_pkg.sv
// shared types and constants for the key click classifier
package kcc_pkg;

	localparam int unsigned TickW  = 8;
	localparam int unsigned LevelW = 2;
	localparam int unsigned CfgIdxW = 2;

	typedef logic [TickW-1:0]  tick_t;
	typedef logic [LevelW-1:0] level_t;

	typedef enum logic [2:0] {
		EV_NONE   = 3'd0,
		EV_PRESS  = 3'd1,
		EV_DOUBLE = 3'd2,
		EV_LONG   = 3'd3,
		EV_DLONG  = 3'd4,
		EV_HOLD   = 3'd5
	} event_t;

	typedef enum logic [1:0] {
		MODE_IDLE     = 2'd0,
		MODE_DEBOUNCE = 2'd1,
		MODE_DOWN     = 2'd2,
		MODE_LONG     = 2'd3
	} mode_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_DEBOUNCE = 2'd0,
		REG_LONG     = 2'd1,
		REG_HOLD     = 2'd2,
		REG_GAP      = 2'd3
	} cfg_reg_t;

	localparam tick_t DebounceReset = 8'd3;
	localparam tick_t LongReset     = 8'd100;
	localparam tick_t HoldReset     = 8'd100;
	localparam tick_t GapReset      = 8'd10;

	typedef struct packed {
		tick_t debounce_ticks;
		tick_t long_ticks;
		tick_t hold_ticks;
		tick_t gap_ticks;
	} cfg_t;

endpackage

// File: src/kcc_key_if.sv
// input channel carrying one key sample word
interface kcc_key_if;
	logic valid;
	logic ready;
	logic key1_level;
	logic key2_level;
	logic key3_level;

	modport source (output valid, output key1_level, output key2_level, output key3_level,
		input ready);
	modport sink (input valid, input key1_level, input key2_level, input key3_level,
		output ready);
endinterface

// File: src/kcc_event_if.sv
// output channel carrying one event word
interface kcc_event_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_res;
	logic [1:0] key_id;

	modport source (output valid, output event_res, output key_id, input ready);
	modport sink (input valid, input event_res, input key_id, output ready);
endinterface

// File: src/kcc_cfg_regs.sv
// configuration register bank
module kcc_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [kcc_pkg::CfgIdxW-1:0] cfg_index,
	input  kcc_pkg::tick_t             cfg_data,
	output kcc_pkg::cfg_t              cfg
);

	kcc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks <= kcc_pkg::DebounceReset;
			cfg_q.long_ticks     <= kcc_pkg::LongReset;
			cfg_q.hold_ticks     <= kcc_pkg::HoldReset;
			cfg_q.gap_ticks      <= kcc_pkg::GapReset;
		end else if (cfg_we) begin
			unique case (kcc_pkg::cfg_reg_t'(cfg_index))
				kcc_pkg::REG_DEBOUNCE: cfg_q.debounce_ticks <= cfg_data;
				kcc_pkg::REG_LONG:     cfg_q.long_ticks     <= cfg_data;
				kcc_pkg::REG_HOLD:     cfg_q.hold_ticks     <= cfg_data;
				kcc_pkg::REG_GAP:      cfg_q.gap_ticks      <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: src/kcc_classify.sv
// gesture state machine: one state update and one event per sample
module kcc_classify (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  kcc_pkg::level_t   lvl,
	input  kcc_pkg::cfg_t     cfg,
	output kcc_pkg::event_t   ev,
	output kcc_pkg::level_t   id
);

	kcc_pkg::mode_t  mode_q, mode_d;
	kcc_pkg::level_t last_q, last_d;
	kcc_pkg::tick_t  tick_q, tick_d;
	kcc_pkg::event_t pend_q, pend_d;
	kcc_pkg::level_t held_q, held_d;
	kcc_pkg::tick_t  tick_inc;
	kcc_pkg::tick_t  tick_run;
	logic            same;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= kcc_pkg::MODE_IDLE;
			last_q <= '0;
			tick_q <= '0;
			pend_q <= kcc_pkg::EV_NONE;
			held_q <= '0;
		end else if (step) begin
			mode_q <= mode_d;
			last_q <= last_d;
			tick_q <= tick_d;
			pend_q <= pend_d;
			held_q <= held_d;
		end
	end

	assign same     = (lvl == last_q);
	assign tick_inc = tick_q + kcc_pkg::tick_t'(1);
	assign tick_run = same ? tick_inc : '0;

	always_comb begin
		mode_d = mode_q;
		last_d = last_q;
		tick_d = tick_q;
		pend_d = pend_q;
		held_d = held_q;
		ev     = kcc_pkg::EV_NONE;
		id     = '0;
		unique case (mode_q)
			kcc_pkg::MODE_IDLE: begin
				if (!same) begin
					last_d = lvl;
					held_d = lvl;
					mode_d = kcc_pkg::MODE_DEBOUNCE;
					tick_d = '0;
				end else if (pend_q != kcc_pkg::EV_NONE) begin
					tick_d = tick_inc;
					if (tick_inc == cfg.gap_ticks) begin
						ev     = pend_q;
						id     = held_q;
						pend_d = kcc_pkg::EV_NONE;
						held_d = '0;
					end
				end
			end
			kcc_pkg::MODE_DEBOUNCE: begin
				last_d = lvl;
				mode_d = same ? kcc_pkg::MODE_DEBOUNCE : kcc_pkg::MODE_IDLE;
				tick_d = tick_run;
				if (tick_run == cfg.debounce_ticks) begin
					tick_d = '0;
					mode_d = kcc_pkg::MODE_DOWN;
				end
			end
			kcc_pkg::MODE_DOWN: begin
				tick_d = tick_run;
				if (!same) begin
					last_d = lvl;
					mode_d = kcc_pkg::MODE_IDLE;
					priority case (pend_q)
						kcc_pkg::EV_NONE:  pend_d = kcc_pkg::EV_PRESS;
						kcc_pkg::EV_PRESS: pend_d = kcc_pkg::EV_DOUBLE;
						default:           pend_d = kcc_pkg::EV_NONE;
					endcase
				end
				if (tick_run == cfg.long_ticks) begin
					tick_d = '0;
					mode_d = kcc_pkg::MODE_LONG;
				end
			end
			kcc_pkg::MODE_LONG: begin
				if (!same) begin
					tick_d = '0;
					last_d = lvl;
					mode_d = kcc_pkg::MODE_IDLE;
					priority case (pend_q)
						kcc_pkg::EV_NONE: pend_d = kcc_pkg::EV_LONG;
						kcc_pkg::EV_LONG: pend_d = kcc_pkg::EV_DLONG;
						default:          pend_d = kcc_pkg::EV_NONE;
					endcase
				end else if (tick_inc == cfg.hold_ticks) begin
					ev     = kcc_pkg::EV_HOLD;
					id     = held_q;
					tick_d = '0;
					last_d = '0;
					mode_d = kcc_pkg::MODE_IDLE;
					pend_d = kcc_pkg::EV_NONE;
					held_d = '0;
				end else begin
					tick_d = tick_inc;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: src/key_click_classifier.sv
// key click classifier top level: sample register, classifier, event register
// an accepted sample word reaches its event word through the sample register, then the event register
// throughput: one sample word per cycle while no event word is stalled downstream
// the sample register takes a new word while an event word waits downstream only if it is empty
// arst_n clears the state machine, both valid flags and the config registers to defaults
module key_click_classifier (
	input  logic                        clk,
	input  logic                        arst_n,
	kcc_key_if.sink                     key_in,
	kcc_event_if.source                 evt_out,
	input  logic                        cfg_we,
	input  logic [kcc_pkg::CfgIdxW-1:0] cfg_index,
	input  kcc_pkg::tick_t              cfg_data
);

	kcc_pkg::cfg_t   cfg;
	logic            valid_s1;
	logic [2:0]      keys_s1;
	logic            valid_s2;
	kcc_pkg::event_t ev_s2;
	kcc_pkg::level_t id_s2;
	kcc_pkg::level_t lvl;
	kcc_pkg::event_t ev;
	kcc_pkg::level_t id;
	logic            out_free;
	logic            step;

	kcc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign out_free     = !valid_s2 || evt_out.ready;
	assign step         = valid_s1 && out_free;
	assign key_in.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (key_in.ready) begin
			valid_s1 <= key_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (key_in.ready && key_in.valid) begin
			keys_s1 <= {key_in.key3_level, key_in.key2_level, key_in.key1_level};
		end
	end

	// key one wins, then two, then three
	always_comb begin
		priority if (!keys_s1[0]) lvl = kcc_pkg::level_t'(1);
		else if (!keys_s1[1])     lvl = kcc_pkg::level_t'(2);
		else if (!keys_s1[2])     lvl = kcc_pkg::level_t'(3);
		else                      lvl = '0;
	end

	kcc_classify u_cls (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.lvl    (lvl),
		.cfg    (cfg),
		.ev     (ev),
		.id     (id)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			ev_s2 <= ev;
			id_s2 <= id;
		end
	end

	assign evt_out.valid     = valid_s2;
	assign evt_out.event_res = ev_s2;
	assign evt_out.key_id    = id_s2;

endmodule

// File: src/kcc_checker.sv
// port-level checks for the key click classifier, bound to the top level
module kcc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] event_res,
	input logic [1:0] key_id
);

	// no event word while in reset
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("event word valid during reset");

	// a stalled event word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(key_id))
		else $error("stalled event word changed");

	// event code stays in range
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_res <= 3'd5)
		else $error("event code out of range");

	// no event means no key
	a_none_no_key: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == 3'd0 |-> key_id == 2'd0)
		else $error("key number without event");

	// input side is ready whenever the output side is free
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input stalled with free output");

endmodule

bind key_click_classifier kcc_checker u_kcc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (key_in.ready),
	.out_valid (evt_out.valid),
	.out_ready (evt_out.ready),
	.event_res (evt_out.event_res),
	.key_id    (evt_out.key_id)
);

// File: tb/sv/tb_top.sv
// testbench for key_click_classifier: directed and random key gestures checked against a predictor
module tb_top;
	import kcc_pkg::*;

	localparam int CycleLimit    = 400000;
	localparam int HoldOffCycles = 150;

	typedef struct {
		event_t ev;
		level_t id;
	} key_event_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CfgIdxW-1:0] cfg_index;
	tick_t cfg_data;

	kcc_key_if   key_if();
	kcc_event_if evt_if();

	key_click_classifier u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_in    (key_if),
		.evt_out   (evt_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// gesture predictor state
	cfg_t   cfg_shadow = '{DebounceReset, LongReset, HoldReset, GapReset};
	mode_t  pred_mode    = MODE_IDLE;
	level_t pred_level   = '0;
	tick_t  pred_tick    = '0;
	event_t pred_pending = EV_NONE;
	level_t pred_held    = '0;

	key_event_t events_due[$];
	int  err_count      = 0;
	int  cycle_count    = 0;
	int  samples_sent   = 0;
	bit  src_gaps_on    = 1'b1;
	bit  sink_stalls_on = 1'b1;
	logic hold_off_on;
	event hold_off_kick;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		err_count++;
		if (err_count <= 100)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	function automatic void classify_tick(input logic [2:0] pins, output event_t ev,
		output level_t id);
		level_t lvl;
		ev = EV_NONE;
		id = '0;
		if (!pins[0]) lvl = 2'd1;
		else if (!pins[1]) lvl = 2'd2;
		else if (!pins[2]) lvl = 2'd3;
		else lvl = 2'd0;
		case (pred_mode)
			MODE_IDLE: begin
				if (lvl != pred_level) begin
					pred_level = lvl;
					pred_held = lvl;
					pred_mode = MODE_DEBOUNCE;
					pred_tick = '0;
				end else if (pred_pending != EV_NONE) begin
					pred_tick = pred_tick + 8'd1;
					if (pred_tick == cfg_shadow.gap_ticks) begin
						ev = pred_pending;
						id = pred_held;
						pred_pending = EV_NONE;
						pred_held = '0;
						pred_level = lvl;
					end
				end
			end
			MODE_DEBOUNCE: begin
				if (pred_level == lvl) begin
					pred_tick = pred_tick + 8'd1;
				end else begin
					pred_tick = '0;
					pred_mode = MODE_IDLE;
					pred_level = lvl;
				end
				if (pred_tick == cfg_shadow.debounce_ticks) begin
					pred_tick = '0;
					pred_mode = MODE_DOWN;
				end
			end
			MODE_DOWN: begin
				if (pred_level == lvl) begin
					pred_tick = pred_tick + 8'd1;
				end else begin
					pred_tick = '0;
					pred_level = lvl;
					if (pred_pending == EV_NONE) pred_pending = EV_PRESS;
					else if (pred_pending == EV_PRESS) pred_pending = EV_DOUBLE;
					else pred_pending = EV_NONE;
					pred_mode = MODE_IDLE;
				end
				if (pred_tick == cfg_shadow.long_ticks) begin
					pred_tick = '0;
					pred_mode = MODE_LONG;
				end
			end
			default: begin
				if (pred_level != lvl) begin
					pred_tick = '0;
					if (pred_pending == EV_NONE) pred_pending = EV_LONG;
					else if (pred_pending == EV_LONG) pred_pending = EV_DLONG;
					else pred_pending = EV_NONE;
					pred_mode = MODE_IDLE;
					pred_level = lvl;
				end else begin
					pred_tick = pred_tick + 8'd1;
					if (pred_tick == cfg_shadow.hold_ticks) begin
						ev = EV_HOLD;
						id = pred_held;
						pred_tick = '0;
						pred_level = '0;
						pred_mode = MODE_IDLE;
						pred_pending = EV_NONE;
						pred_held = '0;
					end
				end
			end
		endcase
	endfunction

	// pins[0] is key one, low means pressed
	task automatic send_pins(input logic [2:0] pins);
		key_event_t due;
		if (src_gaps_on && $urandom_range(0, 7) == 0) begin
			key_if.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		key_if.valid <= 1'b1;
		key_if.key1_level <= pins[0];
		key_if.key2_level <= pins[1];
		key_if.key3_level <= pins[2];
		@(posedge clk);
		while (!key_if.ready) @(posedge clk);
		classify_tick(pins, due.ev, due.id);
		events_due.push_back(due);
		samples_sent++;
	endtask

	task automatic tap(input logic [2:0] pins, input int down_len, input int up_len);
		repeat (down_len) send_pins(pins);
		repeat (up_len) send_pins(3'b111);
	endtask

	task automatic wait_quiet();
		key_if.valid <= 1'b0;
		while (events_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input tick_t val);
		wait_quiet();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DEBOUNCE: cfg_shadow.debounce_ticks = val;
			REG_LONG:     cfg_shadow.long_ticks = val;
			REG_HOLD:     cfg_shadow.hold_ticks = val;
			default:      cfg_shadow.gap_ticks = val;
		endcase
	endtask

	task automatic set_config(input tick_t dbn, input tick_t lng, input tick_t hld,
		input tick_t gap);
		write_reg(REG_DEBOUNCE, dbn);
		write_reg(REG_LONG, lng);
		write_reg(REG_HOLD, hld);
		write_reg(REG_GAP, gap);
	endtask

	task automatic play_gesture();
		logic [2:0] down_pins;
		logic [2:0] other_pins;
		int pick;
		int reach;
		int down_len;
		int up_len;
		pick = $urandom_range(0, 9);
		reach = int'(cfg_shadow.debounce_ticks) + int'(cfg_shadow.long_ticks)
			+ 2 * int'(cfg_shadow.hold_ticks) + 4;
		down_pins = 3'b111;
		down_pins[$urandom_range(0, 2)] = 1'b0;
		if ($urandom_range(0, 1))
			down_len = $urandom_range(1, int'(cfg_shadow.debounce_ticks)
				+ int'(cfg_shadow.long_ticks) + 1);
		else
			down_len = $urandom_range(1, reach);
		up_len = $urandom_range(0, int'(cfg_shadow.gap_ticks) + 3);
		if (pick == 0) begin
			repeat ($urandom_range(1, 8)) send_pins(3'($urandom_range(0, 7)));
		end else begin
			if (pick == 1) down_pins = down_pins & 3'($urandom_range(0, 7));
			if (pick == 2) repeat ($urandom_range(1, 3)) begin
				send_pins(down_pins);
				send_pins(3'b111);
			end
			repeat (down_len) send_pins(down_pins);
			if (pick == 3) begin
				other_pins = 3'b111;
				other_pins[$urandom_range(0, 2)] = 1'b0;
				repeat ($urandom_range(1, reach)) send_pins(other_pins);
			end
			repeat (up_len) send_pins(3'b111);
		end
	endtask

	task automatic test_reset_defaults();
		tap(3'b110, 5, 12);
	endtask

	task automatic test_each_gesture();
		set_config(8'd1, 8'd1, 8'd2, 8'd1);
		tap(3'b110, 2, 1);
		tap(3'b101, 2, 0);
		tap(3'b101, 2, 1);
		tap(3'b011, 3, 0);
		tap(3'b011, 3, 1);
		tap(3'b110, 5, 0);
		// all keys down, then key one lets go while the others stay
		tap(3'b000, 2, 0);
		tap(3'b001, 3, 3);
		tap(3'b110, 2, 0);
		tap(3'b110, 2, 0);
		tap(3'b110, 2, 2);
	endtask

	task automatic test_zero_registers();
		set_config(8'd0, 8'd0, 8'd0, 8'd0);
		tap(3'b110, 3, 3);
		tap(3'b101, 1, 1);
		tap(3'b011, 4, 2);
		repeat (4) play_gesture();
	endtask

	task automatic test_register_extremes();
		set_config(8'd255, 8'd255, 8'd255, 8'd255);
		tap(3'b101, 780, 20);
		set_config(8'd1, 8'd1, 8'd1, 8'd1);
		tap(3'b110, 6, 2);
		tap(3'b011, 2, 3);
	endtask

	task automatic test_midcount_wrap();
		set_config(8'd1, 8'd200, 8'd50, 8'd2);
		repeat (60) send_pins(3'b011);
		write_reg(REG_LONG, 8'd10);
		tap(3'b011, 300, 10);
	endtask

	task automatic test_backpressure();
		set_config(8'd2, 8'd6, 8'd4, 8'd3);
		wait_quiet();
		-> hold_off_kick;
		repeat (10) play_gesture();
	endtask

	task automatic test_random_gestures();
		int phase;
		int stop_at;
		for (phase = 0; phase < 5; phase++) begin
			if (phase == 0)
				set_config(8'd1, 8'd1, 8'd1, 8'd1);
			else if (phase == 3)
				set_config(8'($urandom_range(1, 20)), 8'($urandom_range(1, 30)),
					8'($urandom_range(1, 20)), 8'($urandom_range(1, 15)));
			else
				set_config(8'($urandom_range(1, 4)), 8'($urandom_range(1, 12)),
					8'($urandom_range(1, 8)), 8'($urandom_range(1, 6)));
			if (phase == 4) begin
				wait_quiet();
				src_gaps_on = 1'b0;
				sink_stalls_on = 1'b0;
			end
			stop_at = samples_sent + 70;
			while (samples_sent < stop_at) play_gesture();
		end
	endtask

	initial begin : sink_ready_proc
		int stall_left;
		stall_left = 0;
		evt_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_on) begin
				evt_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				evt_if.ready <= 1'b0;
				stall_left--;
			end else if (sink_stalls_on && $urandom_range(0, 9) == 0) begin
				evt_if.ready <= 1'b0;
				stall_left = $urandom_range(0, 5);
			end else begin
				evt_if.ready <= 1'b1;
			end
		end
	end

	initial begin : hold_off_proc
		hold_off_on <= 1'b0;
		forever begin
			@(hold_off_kick);
			hold_off_on <= 1'b1;
			repeat (HoldOffCycles) @(posedge clk);
			hold_off_on <= 1'b0;
		end
	end

	always @(posedge clk) begin
		key_event_t want;
		if (arst_n && evt_if.valid && evt_if.ready) begin
			if (events_due.size() == 0) begin
				report_mismatch("event word with none expected");
			end else begin
				want = events_due.pop_front();
				if (evt_if.event_res !== want.ev)
					report_mismatch($sformatf("event_res %0d, expected %0d",
						evt_if.event_res, want.ev));
				if (evt_if.key_id !== want.id)
					report_mismatch($sformatf("key_id %0d, expected %0d",
						evt_if.key_id, want.id));
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		key_if.valid <= 1'b0;
		key_if.key1_level <= 1'b1;
		key_if.key2_level <= 1'b1;
		key_if.key3_level <= 1'b1;
		cfg_we <= 1'b0;
		cfg_index <= REG_DEBOUNCE;
		cfg_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_each_gesture();
		test_zero_registers();
		test_register_extremes();
		test_midcount_wrap();
		test_backpressure();
		test_random_gestures();
		wait_quiet();
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
